FILE: src/olwt_pkg.sv
`timescale 1ns / 1ps
package olwt_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int FIRST_LAYER_DEF = 2;
  localparam int LAST_LAYER_DEF  = 3;
  localparam int LAYER_COUNT_DEF = 4;

  localparam int LAYER_W = 3;

  typedef enum logic [1:0] {
    ACT_OPEN    = 2'd0,
    ACT_PRESENT = 2'd1,
    ACT_CLOSE   = 2'd2,
    ACT_HIT     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_COPY    = 3'd1,
    ST_REFUSED = 3'd2,
    ST_NO_WIN  = 3'd3,
    ST_BAD     = 3'd4,
    ST_NO_SLOT = 3'd5,
    ST_NO_COPY = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    REG_SCREEN_W   = 2'd0,
    REG_SCREEN_H   = 2'd1,
    REG_LAYERS     = 2'd2,
    REG_MAX_PIXELS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic        layers_present;
    logic [23:0] max_window_pixels;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic walk_last;
  } stat_t;

endpackage

FILE: src/overlay_layer_window_table_top.sv
`timescale 1ns / 1ps
// Channel   Handshake                          Payload
// request   start, busy (taken on start&!busy) action, task_req, pos_x, pos_y, width, height
// result    done (one cycle)                   status, layer_index, hit_owner
// config    psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// Each request steps through a capture, a walk over every slot of the table, and a decide
// and update step; the result shows on the cycle after the update.
// busy is high from the capture edge until the update edge; a new request may start
// in the same cycle the result shows.
// Synchronous active-high reset empties the table and frees every layer.
// The receiver cannot stall: done lasts one cycle and the result registers hold until the next.
module overlay_layer_window_table_top
  import olwt_pkg::*;
#(
  parameter int SLOTS              = SLOTS_DEF,
  parameter int FIRST_WINDOW_LAYER = FIRST_LAYER_DEF,
  parameter int LAST_WINDOW_LAYER  = LAST_LAYER_DEF,
  parameter int LAYER_COUNT        = LAYER_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [15:0] task_req,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [11:0] width,
  input  logic [11:0] height,
  output logic        done,
  output logic [2:0]  status,
  output logic signed [2:0] layer_index,
  output logic [15:0] hit_owner,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width      <= '0;
      cfg.screen_height     <= '0;
      cfg.layers_present    <= 1'b1;
      cfg.max_window_pixels <= 24'd4194304;
    end else if (wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_SCREEN_W:   cfg.screen_width      <= pwdata[11:0];
        REG_SCREEN_H:   cfg.screen_height     <= pwdata[11:0];
        REG_LAYERS:     cfg.layers_present    <= pwdata[0];
        REG_MAX_PIXELS: cfg.max_window_pixels <= pwdata[23:0];
        default:        cfg.screen_width      <= cfg.screen_width;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_SCREEN_W:   prdata = {20'd0, cfg.screen_width};
      REG_SCREEN_H:   prdata = {20'd0, cfg.screen_height};
      REG_LAYERS:     prdata = {31'd0, cfg.layers_present};
      REG_MAX_PIXELS: prdata = {8'd0, cfg.max_window_pixels};
      default:        prdata = '0;
    endcase
  end

  olwt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  olwt_dp #(
    .SLOTS              (SLOTS),
    .FIRST_WINDOW_LAYER (FIRST_WINDOW_LAYER),
    .LAST_WINDOW_LAYER  (LAST_WINDOW_LAYER),
    .LAYER_COUNT        (LAYER_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg         (cfg),
    .action      (action),
    .task_req    (task_req),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .width       (width),
    .height      (height),
    .done        (done),
    .status      (status),
    .layer_index (layer_index),
    .hit_owner   (hit_owner)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request transfer did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done) else $error("result right after request transfer");

  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    (done && hit_owner != 16'd0) |-> (status == ST_OK && layer_index != -3'sd2))
    else $error("hit owner with bad status");

endmodule

FILE: src/olwt_ctrl.sv
`timescale 1ns / 1ps
module olwt_ctrl
  import olwt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (stat.walk_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: src/olwt_dp.sv
`timescale 1ns / 1ps
module olwt_dp
  import olwt_pkg::*;
#(
  parameter int SLOTS              = SLOTS_DEF,
  parameter int FIRST_WINDOW_LAYER = FIRST_LAYER_DEF,
  parameter int LAST_WINDOW_LAYER  = LAST_LAYER_DEF,
  parameter int LAYER_COUNT        = LAYER_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  cfg_t        cfg,
  input  logic [1:0]  action,
  input  logic [15:0] task_req,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [11:0] width,
  input  logic [11:0] height,
  output logic        done,
  output logic [2:0]  status,
  output logic signed [2:0] layer_index,
  output logic [15:0] hit_owner
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIW = $clog2(LAYER_COUNT);

  logic [15:0]              slot_owner  [SLOTS];
  logic [11:0]              slot_width  [SLOTS];
  logic [11:0]              slot_height [SLOTS];
  logic [11:0]              slot_x      [SLOTS];
  logic [11:0]              slot_y      [SLOTS];
  logic signed [LAYER_W-1:0] slot_layer [SLOTS];
  logic [15:0]              slot_moves  [SLOTS];
  logic                     slot_placed [SLOTS];
  logic [15:0]              layer_holder [LAYER_COUNT];
  logic                     layers_known_flag;
  logic                     layers_exist_flag;

  action_t     req_act;
  logic [15:0] req_task;
  logic [11:0] req_x, req_y, req_w, req_h;
  logic        req_bad;
  logic [23:0] area;

  logic [IW-1:0] idx;
  logic          s_found, free_found;
  logic [IW-1:0] s_idx, free_idx;
  logic          user_found [LAYER_COUNT];
  logic          user_still [LAYER_COUNT];
  logic [IW-1:0] user_idx   [LAYER_COUNT];
  logic signed [LAYER_W-1:0] best;
  logic [15:0]   best_owner;

  logic [15:0] w_owner;
  logic        w_hit;

  assign area           = 24'(width) * 24'(height);
  assign stat.walk_last = (idx == IW'(SLOTS - 1));
  assign w_owner        = slot_owner[idx];
  assign w_hit = (w_owner != 16'd0) && slot_placed[idx] &&
                 (req_x >= slot_x[idx]) && (req_y >= slot_y[idx]) &&
                 ({1'b0, req_x} < {1'b0, slot_x[idx]} + {1'b0, slot_width[idx]}) &&
                 ({1'b0, req_y} < {1'b0, slot_y[idx]} + {1'b0, slot_height[idx]});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_act    <= action_t'(action);
      req_task   <= task_req;
      req_x      <= pos_x;
      req_y      <= pos_y;
      req_w      <= width;
      req_h      <= height;
      req_bad    <= (width == 12'd0) || (height == 12'd0) ||
                    (area > cfg.max_window_pixels);
      idx        <= '0;
      s_found    <= 1'b0;
      free_found <= 1'b0;
      s_idx      <= '0;
      free_idx   <= '0;
      best       <= -3'sd2;
      best_owner <= '0;
      for (int l = 0; l < LAYER_COUNT; l++) begin
        user_found[l] <= 1'b0;
        user_still[l] <= 1'b0;
        user_idx[l]   <= '0;
      end
    end else if (cmd.step) begin
      if (!stat.walk_last) begin
        idx <= idx + 1'b1;
      end
      if (!s_found && w_owner == req_task) begin
        s_found <= 1'b1;
        s_idx   <= idx;
      end
      if (!free_found && w_owner == 16'd0) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      for (int l = 0; l < LAYER_COUNT; l++) begin
        if (!user_found[l] && w_owner != 16'd0 && w_owner == layer_holder[l]) begin
          user_found[l] <= 1'b1;
          user_still[l] <= (slot_moves[idx] == 16'd0);
          user_idx[l]   <= idx;
        end
      end
      if (w_hit && slot_layer[idx] > best) begin
        best       <= slot_layer[idx];
        best_owner <= w_owner;
      end
    end
  end

  logic                      moved;
  logic [15:0]               moves_new;
  logic signed [LAYER_W-1:0] cur_layer;
  logic                      first, back;
  logic                      up_ok, dn_ok, st_ok, pick_ok;
  logic [LIW-1:0]            up_l, dn_l, st_l, pick_l;
  logic                      shown, grant, known_set, known_n, exist_n;
  status_t                   pres_status;
  logic                      s_valid;

  always_comb begin
    moved     = (slot_x[s_idx] != req_x) || (slot_y[s_idx] != req_y);
    moves_new = (moved && slot_moves[s_idx] != 16'hFFFF) ?
                slot_moves[s_idx] + 16'd1 : slot_moves[s_idx];
    cur_layer = slot_layer[s_idx];
    first     = (cur_layer < 0);
    back      = (cfg.screen_width != 12'd0) && (cfg.screen_height != 12'd0) &&
                (slot_width[s_idx] >= cfg.screen_width) &&
                (slot_height[s_idx] >= cfg.screen_height);
    up_ok = 1'b0; dn_ok = 1'b0; st_ok = 1'b0;
    up_l  = '0;   dn_l  = '0;   st_l  = '0;
    for (int l = 0; l < LAYER_COUNT; l++) begin
      if (l >= FIRST_WINDOW_LAYER && l <= LAST_WINDOW_LAYER && layer_holder[l] == 16'd0) begin
        dn_ok = 1'b1;
        dn_l  = LIW'(l);
      end
    end
    for (int l = LAYER_COUNT - 1; l >= 0; l--) begin
      if (l >= FIRST_WINDOW_LAYER && l <= LAST_WINDOW_LAYER) begin
        if (layer_holder[l] == 16'd0) begin
          up_ok = 1'b1;
          up_l  = LIW'(l);
        end
        if (user_found[l] && user_still[l]) begin
          st_ok = 1'b1;
          st_l  = LIW'(l);
        end
      end
    end
    pick_ok = 1'b0;
    pick_l  = '0;
    if (!first) begin
      pick_ok = 1'b1;
    end else if (back && up_ok) begin
      pick_ok = 1'b1;
      pick_l  = up_l;
    end else if (!back && dn_ok) begin
      pick_ok = 1'b1;
      pick_l  = dn_l;
    end else if (moves_new != 16'd0 && st_ok) begin
      pick_ok = 1'b1;
      pick_l  = st_l;
    end
    shown     = pick_ok && (!first || cfg.layers_present);
    grant     = pick_ok && first && cfg.layers_present;
    known_set = pick_ok && first && !cfg.layers_present;
    known_n   = layers_known_flag || known_set || grant;
    exist_n   = layers_exist_flag || grant;
    priority if (shown) begin
      pres_status = ST_OK;
    end else if (known_n && exist_n && moves_new != 16'd0) begin
      pres_status = ST_REFUSED;
    end else if (cfg.screen_width == 12'd0) begin
      pres_status = ST_NO_COPY;
    end else begin
      pres_status = ST_COPY;
    end
    s_valid = s_found && (req_task != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_owner[i]  <= '0;
        slot_width[i]  <= '0;
        slot_height[i] <= '0;
        slot_x[i]      <= '0;
        slot_y[i]      <= '0;
        slot_layer[i]  <= -3'sd1;
        slot_moves[i]  <= '0;
        slot_placed[i] <= 1'b0;
      end
      for (int l = 0; l < LAYER_COUNT; l++) begin
        layer_holder[l] <= '0;
      end
      layers_known_flag <= 1'b0;
      layers_exist_flag <= 1'b0;
      done              <= 1'b0;
      status            <= '0;
      layer_index       <= -3'sd1;
      hit_owner         <= '0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit) begin
        status      <= ST_OK;
        layer_index <= -3'sd1;
        hit_owner   <= '0;
        unique case (req_act)
          ACT_OPEN: begin
            if (req_bad || s_found) begin
              status <= ST_BAD;
            end else if (!free_found) begin
              status <= ST_NO_SLOT;
            end else begin
              slot_owner[free_idx]  <= req_task;
              slot_width[free_idx]  <= req_w;
              slot_height[free_idx] <= req_h;
              slot_x[free_idx]      <= '0;
              slot_y[free_idx]      <= '0;
              slot_layer[free_idx]  <= -3'sd1;
              slot_moves[free_idx]  <= '0;
            end
          end
          ACT_PRESENT: begin
            if (!s_valid) begin
              status <= ST_NO_WIN;
            end else begin
              status               <= pres_status;
              slot_moves[s_idx]    <= moves_new;
              layers_known_flag    <= known_n;
              layers_exist_flag    <= exist_n;
              layer_index          <= cur_layer;
              if (grant) begin
                if (user_found[pick_l] && user_idx[pick_l] != s_idx) begin
                  slot_layer[user_idx[pick_l]] <= -3'sd1;
                end
                layer_holder[pick_l] <= req_task;
                slot_layer[s_idx]    <= LAYER_W'(pick_l);
                layer_index          <= LAYER_W'(pick_l);
              end
              if (pres_status == ST_OK || pres_status == ST_COPY) begin
                slot_x[s_idx]      <= req_x;
                slot_y[s_idx]      <= req_y;
                slot_placed[s_idx] <= 1'b1;
              end
            end
          end
          ACT_CLOSE: begin
            if (!s_valid) begin
              status <= ST_NO_WIN;
            end else begin
              if (cur_layer >= 0 && 32'(cur_layer) < LAYER_COUNT) begin
                layer_holder[LIW'($unsigned(cur_layer))] <= '0;
              end
              slot_layer[s_idx] <= -3'sd1;
              slot_moves[s_idx] <= '0;
              slot_owner[s_idx] <= '0;
            end
          end
          ACT_HIT: begin
            hit_owner <= best_owner;
            if (best >= 0) begin
              layer_index <= best;
            end
          end
          default: begin
            status <= ST_OK;
          end
        endcase
      end
    end
  end

endmodule

FILE: tb/overlay_layer_window_table_top_test.sv
`timescale 1ns / 1ps
module overlay_layer_window_table_top_test;
  import olwt_pkg::*;

  localparam int NSLOT = 8;
  localparam int FIRST_L = 2;
  localparam int LAST_L = 3;
  localparam int NLAYER = 4;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  layer_index;
    logic [15:0] hit_owner;
  } window_result_t;

  class window_table_scoreboard;
    logic [11:0] scr_w, scr_h;
    logic        layers_on;
    logic [23:0] max_pix;
    logic [15:0] owner_q[NSLOT];
    logic [11:0] w_q[NSLOT], h_q[NSLOT], x_q[NSLOT], y_q[NSLOT];
    int          layer_q[NSLOT];
    logic [16:0] moves_q[NSLOT];
    bit          placed_q[NSLOT];
    logic [15:0] holder_q[NLAYER];
    bit          known, exists;
    window_result_t pending[$];
    int          mismatches;
    int          checked;

    function void clear_table();
      for (int i = 0; i < NSLOT; i++) begin
        owner_q[i] = 0; w_q[i] = 0; h_q[i] = 0; x_q[i] = 0; y_q[i] = 0;
        layer_q[i] = -1; moves_q[i] = 0; placed_q[i] = 0;
      end
      for (int l = 0; l < NLAYER; l++) holder_q[l] = 0;
      known = 0; exists = 0;
      scr_w = 0; scr_h = 0; layers_on = 1; max_pix = 24'd4194304;
      mismatches = 0; checked = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_SCREEN_W:   scr_w = v[11:0];
        REG_SCREEN_H:   scr_h = v[11:0];
        REG_LAYERS:     layers_on = v[0];
        REG_MAX_PIXELS: max_pix = v[23:0];
      endcase
    endfunction

    function int slot_of(logic [15:0] t);
      for (int i = 0; i < NSLOT; i++) if (owner_q[i] == t) return i;
      return -1;
    endfunction

    function int user_of(int l);
      for (int i = 0; i < NSLOT; i++)
        if (owner_q[i] != 0 && owner_q[i] == holder_q[l]) return i;
      return -1;
    endfunction

    function int select_layer(int s);
      bit back;
      int u;
      if (layer_q[s] >= 0) return layer_q[s];
      back = scr_w != 0 && scr_h != 0 && w_q[s] >= scr_w && h_q[s] >= scr_h;
      if (back) begin
        for (int l = FIRST_L; l <= LAST_L; l++) if (holder_q[l] == 0) return l;
      end else begin
        for (int l = LAST_L; l >= FIRST_L; l--) if (holder_q[l] == 0) return l;
      end
      if (moves_q[s] == 0) return -1;
      for (int l = FIRST_L; l <= LAST_L; l++) begin
        u = user_of(l);
        if (u >= 0 && moves_q[u] == 0) return l;
      end
      return -1;
    endfunction

    function bit place_on_layer(int s);
      int l, u;
      l = select_layer(s);
      if (l < 0) return 0;
      if (layer_q[s] >= 0) return 1;
      if (!layers_on) begin
        known = 1;
        return 0;
      end
      u = user_of(l);
      if (u >= 0 && u != s) layer_q[u] = -1;
      holder_q[l] = owner_q[s];
      layer_q[s] = l;
      known = 1; exists = 1;
      return 1;
    endfunction

    function void note_request(action_t act, logic [15:0] t, logic [11:0] px, logic [11:0] py,
                               logic [11:0] w, logic [11:0] h);
      window_result_t r;
      int s, best;
      r.status = ST_OK; r.hit_owner = 0;
      best = -1;
      case (act)
        ACT_OPEN: begin
          if (w == 0 || h == 0 || 32'(w) * 32'(h) > 32'(max_pix)) r.status = ST_BAD;
          else if (slot_of(t) >= 0) r.status = ST_BAD;
          else begin
            s = slot_of(0);
            if (s < 0) r.status = ST_NO_SLOT;
            else begin
              owner_q[s] = t; w_q[s] = w; h_q[s] = h; x_q[s] = 0; y_q[s] = 0;
              layer_q[s] = -1; moves_q[s] = 0;
            end
          end
        end
        ACT_PRESENT: begin
          s = t != 0 ? slot_of(t) : -1;
          if (s < 0) r.status = ST_NO_WIN;
          else begin
            if ((x_q[s] != px || y_q[s] != py) && moves_q[s] < 17'hFFFF) moves_q[s]++;
            if (place_on_layer(s)) r.status = ST_OK;
            else if (known && exists && moves_q[s] != 0) r.status = ST_REFUSED;
            else if (scr_w == 0) r.status = ST_NO_COPY;
            else r.status = ST_COPY;
            if (r.status == ST_OK || r.status == ST_COPY) begin
              x_q[s] = px; y_q[s] = py; placed_q[s] = 1;
            end
            best = layer_q[s];
          end
        end
        ACT_CLOSE: begin
          s = t != 0 ? slot_of(t) : -1;
          if (s < 0) r.status = ST_NO_WIN;
          else begin
            if (layer_q[s] >= 0) holder_q[layer_q[s]] = 0;
            layer_q[s] = -1; moves_q[s] = 0; owner_q[s] = 0;
          end
        end
        default: begin
          best = -2;
          for (int i = 0; i < NSLOT; i++) begin
            if (owner_q[i] == 0 || !placed_q[i]) continue;
            if (px < x_q[i] || py < y_q[i] || 13'(px) >= 13'(x_q[i]) + 13'(w_q[i]) ||
                13'(py) >= 13'(y_q[i]) + 13'(h_q[i])) continue;
            if (layer_q[i] > best) begin
              best = layer_q[i]; r.hit_owner = owner_q[i];
            end
          end
          if (best < 0) best = -1;
        end
      endcase
      r.layer_index = best[2:0];
      pending.push_back(r);
    endfunction

    function void check_result(window_result_t got);
      window_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d layer %0d owner %0d, got %0d %0d %0d",
                   exp_r.status, $signed(exp_r.layer_index), exp_r.hit_owner,
                   got.status, $signed(got.layer_index), got.hit_owner);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0, psel = 0, penable = 0, pwrite = 0;
  logic busy, done, pready;
  logic [1:0] action = 0;
  logic [15:0] task_req = 0, hit_owner;
  logic [11:0] pos_x = 0, pos_y = 0, width = 0, height = 0;
  logic [2:0] status;
  logic signed [2:0] layer_index;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  bit quiet = 0;
  int accepted = 0;
  window_table_scoreboard board;
  logic [15:0] tasks[6] = '{16'd1, 16'd2, 16'd3, 16'hFFFF, 16'h8000, 16'h00AA};

  overlay_layer_window_table_top i_dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk)
    if (!rst && done) board.check_result('{status, layer_index, hit_owner});

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, v);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic request(action_t a, logic [15:0] t, logic [11:0] px, logic [11:0] py,
                         logic [11:0] w, logic [11:0] h);
    @(negedge clk);
    if (!quiet && $urandom_range(3) == 0) repeat ($urandom_range(1, 9)) @(negedge clk);
    action <= a; task_req <= t; pos_x <= px; pos_y <= py; width <= w; height <= h;
    start <= 1;
    do @(posedge clk); while (busy);
    board.note_request(a, t, px, py, w, h);
    accepted++;
    @(negedge clk);
    start <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic random_request();
    logic [15:0] t;
    int k;
    t = $urandom_range(9) == 0 ? 16'($urandom) : tasks[$urandom_range(5)];
    if ($urandom_range(19) == 0) t = 0;
    k = $urandom_range(9);
    if (k < 2) begin
      if ($urandom_range(7) == 0)
        request(ACT_OPEN, t, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
      else if ($urandom_range(3) == 0)
        request(ACT_OPEN, t, 0, 0, 12'($urandom_range(2000, 4095)),
                12'($urandom_range(1000, 4095)));
      else
        request(ACT_OPEN, t, 0, 0, 12'($urandom_range(1, 300)), 12'($urandom_range(1, 300)));
    end else if (k < 6) begin
      request(ACT_PRESENT, t, $urandom_range(3) == 0 ? 12'd0 : 12'($urandom_range(0, 600)),
              12'($urandom_range(0, 600)), 12'($urandom), 12'($urandom));
    end else if (k < 7) begin
      request(ACT_CLOSE, t, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    end else begin
      request(ACT_HIT, 16'($urandom), $urandom_range(3) == 0 ? 12'($urandom) :
              12'($urandom_range(0, 900)), 12'($urandom_range(0, 900)),
              12'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    board = new();
    board.clear_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    request(ACT_OPEN, 0, 0, 0, 10, 10);
    request(ACT_OPEN, 1, 0, 0, 0, 10);
    request(ACT_OPEN, 1, 0, 0, 10, 0);
    request(ACT_OPEN, 1, 0, 0, 12'hFFF, 12'hFFF);
    request(ACT_OPEN, 1, 0, 0, 100, 100);
    request(ACT_OPEN, 1, 0, 0, 100, 100);
    request(ACT_PRESENT, 1, 5, 5, 0, 0);
    request(ACT_PRESENT, 0, 5, 5, 0, 0);
    request(ACT_OPEN, 16'hFFFF, 0, 0, 1, 1);
    request(ACT_PRESENT, 16'hFFFF, 0, 0, 0, 0);
    request(ACT_OPEN, 3, 0, 0, 50, 50);
    request(ACT_PRESENT, 3, 0, 0, 0, 0);
    request(ACT_PRESENT, 3, 20, 20, 0, 0);
    request(ACT_HIT, 0, 30, 30, 0, 0);
    request(ACT_HIT, 0, 12'hFFF, 12'hFFF, 0, 0);
    request(ACT_CLOSE, 1, 0, 0, 0, 0);
    request(ACT_CLOSE, 0, 0, 0, 0, 0);
    request(ACT_CLOSE, 1, 0, 0, 0, 0);
    for (int i = 0; i < 9; i++) request(ACT_OPEN, 16'(100 + i), 0, 0, 8, 8);
    request(ACT_OPEN, 0, 0, 0, 8, 8);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_SCREEN_W, 640); write_reg(REG_SCREEN_H, 480);
        end
        1: begin
          write_reg(REG_LAYERS, 0); write_reg(REG_MAX_PIXELS, 24'hFFFFFF);
        end
        2: begin
          write_reg(REG_SCREEN_W, 12'hFFF); write_reg(REG_SCREEN_H, 12'hFFF);
          write_reg(REG_LAYERS, 1);
        end
        3: begin
          write_reg(REG_SCREEN_W, 0); write_reg(REG_MAX_PIXELS, 1);
        end
        4: begin
          write_reg(REG_SCREEN_W, 300); write_reg(REG_SCREEN_H, 200);
          write_reg(REG_MAX_PIXELS, 50000);
        end
        default: write_reg(REG_MAX_PIXELS, 24'd4194304);
      endcase
      quiet = ph == 5;
      for (int i = 0; i < 75; i++) begin
        random_request();
        if (i % 30 == 29)
          for (int tk = 0; tk < 6; tk++)
            request(ACT_CLOSE, tasks[tk], 0, 0, 0, 0);
      end
      drain();
    end

    $display("Covered %0d requests, %0d results checked over six register settings.",
             accepted, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
